// ----- design/sorted_key_set_table_assert.svh -----
// Assertion macros shared by the sorted key set table.
// Depends on nothing; users supply clk_i and rst_ni in scope.
`ifndef SORTED_KEY_SET_TABLE_ASSERT_SVH
`define SORTED_KEY_SET_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SKST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted key set table: assertion failed");
`define SKST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted key set table: assertion failed");
`else
`define SKST_ASSERT_IMP(lbl, ante, cons)
`define SKST_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- design/skst_pkg.sv -----
// Shared sizes, codes and types of the sorted key set table.
// Used by the cell, the cell row and the top level.
package skst_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned KEY_BITS    = 32;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KEY_IN_W    = 32;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned RES_W       = 9;

  typedef logic [KEY_BITS-1:0] cell_key_t;
  typedef logic [CNT_W-1:0]    count_t;

  typedef enum logic [1:0] {
    MODE_FIND   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic capture;
    logic ins;
    logic del;
  } row_ctl_t;

  typedef struct packed {
    logic      hit;
    count_t    where;
    cell_key_t rd_key;
  } row_stat_t;

  function automatic cell_key_t to_cell_key(logic [KEY_IN_W-1:0] k);
    logic [KEY_BITS+KEY_IN_W-1:0] w;
    w = {{KEY_BITS{1'b0}}, k};
    return w[KEY_BITS-1:0];
  endfunction

  function automatic logic [KEY_IN_W-1:0] from_cell_key(cell_key_t k);
    logic [KEY_BITS+KEY_IN_W-1:0] w;
    w = {{KEY_IN_W{1'b0}}, k};
    return w[KEY_IN_W-1:0];
  endfunction

endpackage

// ----- design/skst_cell.sv -----
// One cell of the sorted row: holds a key, compares it with the request key
// and shifts toward either neighbor. Depends on skst_pkg.
module skst_cell (
  input  logic                 clk_i,
  input  skst_pkg::row_ctl_t   ctl_i,
  input  logic                 live_i,
  input  skst_pkg::cell_key_t  cmp_key_i,
  input  skst_pkg::cell_key_t  new_key_i,
  input  skst_pkg::cell_key_t  left_key_i,
  input  logic                 left_lt_i,
  input  skst_pkg::cell_key_t  right_key_i,
  output skst_pkg::cell_key_t  key_o,
  output logic                 lt_o,
  output logic                 eq_o
);
  import skst_pkg::*;

  cell_key_t key_q, key_d;
  logic      lt_q, eq_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      lt_q <= live_i && (key_q < cmp_key_i);
      eq_q <= live_i && (key_q == cmp_key_i);
    end
    key_q <= key_d;
  end

  // Cells below the insertion point keep their key. The cell at the insertion
  // point is the first one whose left neighbor is still below the new key.
  always_comb begin
    key_d = key_q;
    if (ctl_i.ins && !lt_q) begin
      key_d = left_lt_i ? new_key_i : left_key_i;
    end else if (ctl_i.del && !lt_q) begin
      key_d = right_key_i;
    end
  end

  assign key_o = key_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

// ----- design/skst_row.sv -----
// Row of key cells with the hit, insertion point and read-select logic.
// Depends on skst_pkg and skst_cell.
module skst_row (
  input  logic                 clk_i,
  input  skst_pkg::row_ctl_t   ctl_i,
  input  skst_pkg::count_t     count_i,
  input  skst_pkg::cell_key_t  cmp_key_i,
  input  skst_pkg::cell_key_t  new_key_i,
  input  logic [skst_pkg::POS_W-1:0] pos_i,
  output skst_pkg::row_stat_t  stat_o
);
  import skst_pkg::*;

  cell_key_t                 keys [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]    lt;
  logic [TABLE_DEPTH-1:0]    eq;
  logic [TABLE_DEPTH-1:0]    sel;
  logic [TABLE_DEPTH:0]      lt_ext;
  logic [TABLE_DEPTH-1:0]    edge_hot;
  count_t                    where;
  cell_key_t                 rd_key;

  for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
    logic      live;
    cell_key_t left_key;
    logic      left_lt;
    cell_key_t right_key;

    assign live = 32'(gi) < 32'(count_i);
    assign sel[gi] = 32'(pos_i) == 32'(gi);

    if (gi == 0) begin : g_first
      assign left_key = new_key_i;
      assign left_lt  = 1'b0;
    end else begin : g_inner
      assign left_key = keys[gi-1];
      assign left_lt  = lt[gi-1];
    end

    if (gi == TABLE_DEPTH - 1) begin : g_last
      assign right_key = keys[gi];
    end else begin : g_body
      assign right_key = keys[gi+1];
    end

    skst_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl_i),
      .live_i      (live),
      .cmp_key_i   (cmp_key_i),
      .new_key_i   (new_key_i),
      .left_key_i  (left_key),
      .left_lt_i   (left_lt),
      .right_key_i (right_key),
      .key_o       (keys[gi]),
      .lt_o        (lt[gi]),
      .eq_o        (eq[gi])
    );
  end

  // The less-than flags of a sorted row form a thermometer code, so the
  // insertion point is one past the last set flag.
  assign lt_ext   = {1'b0, lt};
  assign edge_hot = lt & ~lt_ext[TABLE_DEPTH:1];

  always_comb begin
    where  = '0;
    rd_key = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (edge_hot[i]) begin
        where = where | count_t'(i + 1);
      end
      if (sel[i]) begin
        rd_key = rd_key | keys[i];
      end
    end
  end

  assign stat_o.hit    = |eq;
  assign stat_o.where  = where;
  assign stat_o.rd_key = rd_key;

endmodule

// ----- design/sorted_key_set_table.sv -----
// Sorted key set table: a set of unsigned keys kept in ascending order in a row
// of cells, with find, insert, delete and read-by-position requests, one result
// beat per request beat. For each request, every cell first compares its key
// with the request key and registers the result; then the row works out the
// position, shifts for insert or delete, and the result beat is loaded into
// the output register. A new request beat is taken while an earlier result
// beat still waits on out_stall_i; the shift and the load of the result wait
// for that output register to free. Depends on skst_pkg, skst_row, skst_cell
// and the assertion macros in sorted_key_set_table_assert.svh.
`include "sorted_key_set_table_assert.svh"

module sorted_key_set_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      mode_i,
  input  logic [skst_pkg::KEY_IN_W-1:0]   key_i,
  input  logic [skst_pkg::POS_W-1:0]      position_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic [skst_pkg::RES_W-1:0]      result_position_o,
  output logic [skst_pkg::KEY_IN_W-1:0]   read_key_o,
  output logic [skst_pkg::RES_W-1:0]      entry_count_o
);
  import skst_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_e;

  state_e                state_q, state_d;
  count_t                count_q, count_d;
  mode_e                 mode_q;
  cell_key_t             key_q;
  logic [POS_W-1:0]      pos_q;

  logic                  out_valid_q;
  status_e               status_q, status_d;
  logic [RES_W-1:0]      rpos_q, rpos_d;
  logic [KEY_IN_W-1:0]   rkey_q, rkey_d;
  logic [RES_W-1:0]      cnt_out_q;

  row_ctl_t              ctl;
  row_stat_t             stat;
  logic                  in_accept;
  logic                  out_free;
  logic                  finish;
  logic                  ins_go, del_go;
  logic                  read_ok, full;

  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = (state_q == S_EVAL) && out_free;

  assign ctl.capture = in_accept;
  assign ctl.ins     = finish && ins_go;
  assign ctl.del     = finish && del_go;

  skst_row u_row (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .count_i   (count_q),
    .cmp_key_i (to_cell_key(key_i)),
    .new_key_i (key_q),
    .pos_i     (pos_q),
    .stat_o    (stat)
  );

  assign read_ok = 32'(pos_q) < 32'(count_q);
  assign full    = count_q == count_t'(TABLE_DEPTH);

  always_comb begin
    status_d = ST_OK;
    rpos_d   = RES_W'(stat.where);
    rkey_d   = '0;
    ins_go   = 1'b0;
    del_go   = 1'b0;
    unique case (mode_q)
      MODE_FIND: begin
        status_d = stat.hit ? ST_OK : ST_NOT_FOUND;
      end
      MODE_INSERT: begin
        if (!stat.hit) begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ins_go = 1'b1;
          end
        end
      end
      MODE_DELETE: begin
        if (stat.hit) begin
          del_go = 1'b1;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      MODE_READ: begin
        rpos_d = RES_W'(pos_q);
        if (read_ok) begin
          rkey_d = from_cell_key(stat.rd_key);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: begin
        status_d = ST_NOT_FOUND;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (ctl.ins) begin
      count_d = count_q + count_t'(1);
    end else if (ctl.del) begin
      count_d = count_q - count_t'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (finish) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q <= mode_e'(mode_i);
      key_q  <= to_cell_key(key_i);
      pos_q  <= position_i;
    end
    if (finish) begin
      status_q  <= status_d;
      rpos_q    <= rpos_d;
      rkey_q    <= rkey_d;
      cnt_out_q <= RES_W'(count_d);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign result_position_o = rpos_q;
  assign read_key_o        = rkey_q;
  assign entry_count_o     = cnt_out_q;

  `SKST_ASSERT_IMP(a_count_bound, 1'b1, 32'(count_q) <= 32'(TABLE_DEPTH))
  `SKST_ASSERT_IMP(a_full_report, out_valid_q && (status_q == ST_FULL), 32'(cnt_out_q) == 32'(TABLE_DEPTH))
  `SKST_ASSERT_NXT(a_insert_grows, ctl.ins, count_q == $past(count_q) + count_t'(1))
  `SKST_ASSERT_NXT(a_accept_evals, in_accept, state_q == S_EVAL)

endmodule
